@@ design/awm_pkg.sv @@
// Shared types and codes for the anagram window matcher.
package awm_pkg;

  localparam int MODE_W   = 2;
  localparam int LETTER_W = 5;
  localparam int START_W  = 16;
  localparam int STATUS_W = 2;
  localparam int OP_W     = 3;

  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PATTERN_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INDEX_SAT    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_LETTER   = 2'd3;

  // Work that the back end carries out for one request
  localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 3'd2;
  localparam logic [OP_W-1:0] OP_PATTERN = 3'd3;
  localparam logic [OP_W-1:0] OP_TEXT    = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [LETTER_W-1:0] letter;
    logic                inc;         // add letter to the window
    logic                dec;         // drop old_letter from the window
    logic [LETTER_W-1:0] old_letter;
    logic                check;       // window is full, compare counts
    logic [START_W-1:0]  start;
    logic [STATUS_W-1:0] status;
  } awm_cmd_t;

endpackage

@@ design/awm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read (read-first).
module awm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ design/awm_front.sv @@
// Front end: accepts requests, tracks pattern length, text index and letter ring.
module awm_front import awm_pkg::*; #(
  parameter int ALPHABET_SIZE = 26,
  parameter int MAX_PATTERN   = 64,
  parameter int INDEX_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [MODE_W-1:0]   mode,
  input  logic [LETTER_W-1:0] letter,
  output logic                cmd_valid,
  output awm_cmd_t            cmd,
  input  logic                cmd_full
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SW = CW + 1;

  logic [CW-1:0]         plen, plen_next;
  logic [INDEX_BITS-1:0] pos, pos_next;
  logic [AW-1:0]         slot, slot_next;
  logic [CW-1:0]         fill, fill_next;
  logic                  s1_valid;
  awm_cmd_t              s1_cmd, cmd_new;

  logic                  accept;
  logic                  letter_ok;
  logic                  has_len;
  logic                  drop;
  logic [CW-1:0]         fill_inc;
  logic [SW-1:0]         slot_ext, len_ext, back_ext;
  logic [AW-1:0]         rd_addr;
  logic [31:0]           pos32;
  logic [START_W-1:0]    start_val;
  logic                  ram_we, ram_re;
  logic [LETTER_W-1:0]   ram_rdata;

  assign item_stall = s1_valid && cmd_full;
  assign accept     = item_valid && !item_stall;

  assign letter_ok = {1'b0, letter} < (LETTER_W + 1)'(ALPHABET_SIZE);
  assign has_len   = plen != '0;
  assign drop      = has_len && (fill >= plen);
  assign fill_inc  = (fill == CW'(MAX_PATTERN)) ? fill : fill + CW'(1);

  // Ring slot of the letter that leaves the window
  assign slot_ext = SW'(slot);
  assign len_ext  = SW'(plen);
  assign back_ext = (slot_ext >= len_ext) ? slot_ext - len_ext
                                          : slot_ext + SW'(MAX_PATTERN) - len_ext;
  assign rd_addr  = back_ext[AW-1:0];

  assign pos32     = 32'(pos);
  assign start_val = pos32[START_W-1:0] - START_W'(plen) + START_W'(1);

  always_comb begin
    plen_next          = plen;
    pos_next           = pos;
    slot_next          = slot;
    fill_next          = fill;
    ram_we             = 1'b0;
    ram_re             = 1'b0;
    cmd_new            = '0;
    cmd_new.op         = OP_NONE;
    cmd_new.letter     = letter;
    cmd_new.status     = ST_OK;
    case (mode)
      MODE_CLEAR: begin
        cmd_new.op = OP_CLEAR;
        plen_next  = '0;
        pos_next   = '0;
        slot_next  = '0;
        fill_next  = '0;
      end
      MODE_RESTART: begin
        cmd_new.op = OP_RESTART;
        pos_next   = '0;
        slot_next  = '0;
        fill_next  = '0;
      end
      MODE_PATTERN: begin
        if (!letter_ok) begin
          cmd_new.status = ST_BAD_LETTER;
        end else if (plen == CW'(MAX_PATTERN)) begin
          cmd_new.status = ST_PATTERN_FULL;
        end else begin
          cmd_new.op = OP_PATTERN;
          plen_next  = plen + CW'(1);
          pos_next   = '0;
          slot_next  = '0;
          fill_next  = '0;
        end
      end
      MODE_TEXT: begin
        if (!letter_ok) begin
          cmd_new.status = ST_BAD_LETTER;
        end else begin
          cmd_new.op    = OP_TEXT;
          cmd_new.inc   = has_len;
          cmd_new.dec   = drop;
          cmd_new.check = has_len && (fill_inc >= plen);
          cmd_new.start = start_val;
          if (&pos) begin
            cmd_new.status = ST_INDEX_SAT;
          end else begin
            pos_next = pos + INDEX_BITS'(1);
          end
          slot_next = (slot == AW'(MAX_PATTERN - 1)) ? '0 : slot + AW'(1);
          fill_next = fill_inc;
          ram_we    = 1'b1;
          ram_re    = drop;
        end
      end
      default: begin
        cmd_new.op = OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen     <= '0;
      pos      <= '0;
      slot     <= '0;
      fill     <= '0;
      s1_valid <= 1'b0;
    end else if (accept) begin
      plen     <= plen_next;
      pos      <= pos_next;
      slot     <= slot_next;
      fill     <= fill_next;
      s1_valid <= 1'b1;
    end else if (!cmd_full) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd <= cmd_new;
    end
  end

  // Read data holds until the next accepted request, so it stays with s1_cmd
  awm_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (MAX_PATTERN)
  ) u_ring (
    .clk   (clk),
    .we    (accept && ram_we),
    .waddr (slot),
    .wdata (letter),
    .re    (accept && ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cmd            = s1_cmd;
    cmd.old_letter = ram_rdata;
  end

  assign cmd_valid = s1_valid;

endmodule

@@ design/awm_queue.sv @@
// Two-entry command queue between front and back end.
module awm_queue import awm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  input  awm_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output awm_cmd_t head_cmd
);

  awm_cmd_t   slots [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push_en, pop_en;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head_cmd   = slots[rptr];
  assign push_en    = push_valid && !full;
  assign pop_en     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push_en) begin
        wptr <= ~wptr;
      end
      if (pop_en) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push_en) - 2'(pop_en);
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      slots[wptr] <= push_cmd;
    end
  end

endmodule

@@ design/awm_back.sv @@
// Back end: per-letter count lanes, match compare and output register.
module awm_back import awm_pkg::*; #(
  parameter int ALPHABET_SIZE = 26,
  parameter int MAX_PATTERN   = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  awm_cmd_t            head_cmd,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                match,
  output logic [START_W-1:0]  start_index,
  output logic [STATUS_W-1:0] status
);

  localparam int CW = $clog2(MAX_PATTERN + 1);

  logic [CW-1:0] pcnt  [ALPHABET_SIZE];
  logic [CW-1:0] wcnt  [ALPHABET_SIZE];
  logic [CW-1:0] w_new [ALPHABET_SIZE];
  logic [CW-1:0] w_add [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] eq;
  logic [ALPHABET_SIZE-1:0] hit;
  logic          take;
  logic          match_new;

  assign take = head_valid && (!result_valid || !result_stall);
  assign pop  = take;

  always_comb begin
    for (int k = 0; k < ALPHABET_SIZE; k++) begin
      hit[k]   = head_cmd.letter == LETTER_W'(k);
      w_add[k] = wcnt[k] + CW'(head_cmd.inc && hit[k]);
      w_new[k] = w_add[k];
      if (head_cmd.dec && head_cmd.old_letter == LETTER_W'(k) && w_add[k] != '0) begin
        w_new[k] = w_add[k] - CW'(1);
      end
      eq[k] = w_new[k] == pcnt[k];
    end
  end

  assign match_new = head_cmd.check && (&eq);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ALPHABET_SIZE; k++) begin
        pcnt[k] <= '0;
        wcnt[k] <= '0;
      end
    end else if (take) begin
      for (int k = 0; k < ALPHABET_SIZE; k++) begin
        case (head_cmd.op)
          OP_CLEAR: begin
            pcnt[k] <= '0;
            wcnt[k] <= '0;
          end
          OP_RESTART: begin
            wcnt[k] <= '0;
          end
          OP_PATTERN: begin
            pcnt[k] <= pcnt[k] + CW'(hit[k]);
            wcnt[k] <= '0;
          end
          OP_TEXT: begin
            wcnt[k] <= w_new[k];
          end
          default: begin
            wcnt[k] <= wcnt[k];
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      match       <= match_new;
      start_index <= match_new ? head_cmd.start : '0;
      status      <= head_cmd.status;
    end
  end

endmodule

@@ design/anagram_window_matcher.sv @@
// Top level of the anagram window matcher: front end, command queue, back end.
//
//   channel   handshake                  payload
//   item      item_valid / item_stall    mode[1:0], letter[4:0]
//   result    result_valid / result_stall match, start_index[15:0], status[1:0]
//
// One request is accepted per cycle while item_stall is low; each gives exactly one result,
// passing in turn through the front register, the queue and the output register.
// The letter ring is a RAM with registered read, read at accept time.
// Reset clears all counts and indexes directly; no clearing pass is needed.
// A stalled result fills the two-entry queue, then the front register, then
// item_stall rises.
module anagram_window_matcher import awm_pkg::*; #(
  parameter int ALPHABET_SIZE = 26,
  parameter int MAX_PATTERN   = 64,
  parameter int INDEX_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [MODE_W-1:0]   mode,
  input  logic [LETTER_W-1:0] letter,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                match,
  output logic [START_W-1:0]  start_index,
  output logic [STATUS_W-1:0] status
);

  logic     f_valid;
  awm_cmd_t f_cmd;
  logic     q_full;
  logic     q_valid;
  awm_cmd_t q_cmd;
  logic     q_pop;

  awm_front #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .MAX_PATTERN   (MAX_PATTERN),
    .INDEX_BITS    (INDEX_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .mode       (mode),
    .letter     (letter),
    .cmd_valid  (f_valid),
    .cmd        (f_cmd),
    .cmd_full   (q_full)
  );

  awm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_cmd   (f_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  awm_back #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .MAX_PATTERN   (MAX_PATTERN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_valid),
    .head_cmd     (q_cmd),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .match        (match),
    .start_index  (start_index),
    .status       (status)
  );

  // Nothing is pending right after reset
  assert property (@(posedge clk) rst |=> !result_valid && !item_stall)
    else $error("pending work after reset");

  // An accepted clear request lands in the front register as a clear command
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && mode == MODE_CLEAR |=> f_valid && f_cmd.op == OP_CLEAR)
    else $error("clear request not classified as clear");

  // A letter leaves the window only when a letter enters it
  assert property (@(posedge clk) disable iff (rst)
    q_valid && q_cmd.dec |-> q_cmd.inc && q_cmd.op == OP_TEXT)
    else $error("window drop without add");

  // Matches only come from accepted text letters
  assert property (@(posedge clk) disable iff (rst)
    result_valid && match |-> status != ST_PATTERN_FULL && status != ST_BAD_LETTER)
    else $error("match on a non-text result");

endmodule
